### rtl/core/lkaq_pkg.sv
// Shared types, codes and ladder constants for the keypad scanner with autorepeat.
package lkaq_pkg;

	// Fixed key slots: right, up, left, down, fire
	localparam int KEY_COUNT   = 5;
	localparam int LADDER_KEYS = 4;
	localparam int SAMPLE_W    = 12;
	localparam int TICK_W      = 32;
	localparam int TIME_W      = 31;
	localparam int HALFW_W     = 8;
	localparam int CODE_W      = 3;
	localparam int KIND_W      = 2;
	localparam int REG_IDX_W   = 3;
	localparam int REG_DATA_W  = 31;

	typedef logic [CODE_W-1:0]   code_t;
	typedef logic [KIND_W-1:0]   kind_t;
	typedef logic [TICK_W-1:0]   tick_t;
	typedef logic [TIME_W-1:0]   span_t;
	typedef logic [SAMPLE_W-1:0] sample_t;

	// Item kinds
	localparam kind_t KIND_SCAN  = 2'd0;
	localparam kind_t KIND_READ  = 2'd1;
	localparam kind_t KIND_FLUSH = 2'd2;

	// Key codes
	localparam code_t CODE_NONE = 3'd0;
	localparam code_t CODE_FIRE = 3'd5;

	// Register indexes
	localparam logic [REG_IDX_W-1:0] REG_ENABLE        = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_FIRST_DELAY   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_REPEAT_PERIOD = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_RELEASE_HOLD  = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_WINDOW_HALF   = 3'd4;

	// Register reset values
	localparam span_t             FIRST_DELAY_RST   = 31'd14400000;
	localparam span_t             REPEAT_PERIOD_RST = 31'd4800000;
	localparam span_t             RELEASE_HOLD_RST  = 31'd2400000;
	localparam logic [HALFW_W-1:0] WINDOW_HALF_RST  = 8'd40;

	// Ladder voltages
	localparam sample_t LADDER_N  = 12'd820;
	localparam sample_t LADDER_NE = 12'd1060;
	localparam sample_t LADDER_NW = 12'd2280;
	localparam sample_t LADDER_S  = 12'd1390;
	localparam sample_t LADDER_SE = 12'd1560;
	localparam sample_t LADDER_SW = 12'd2470;
	localparam sample_t LADDER_E  = 12'd370;
	localparam sample_t LADDER_W  = 12'd2040;

	// Three ladder voltages that read each direction key as pressed
	localparam sample_t LADDER_CENTERS [LADDER_KEYS][3] = '{
		'{LADDER_E, LADDER_NE, LADDER_SE},	// right
		'{LADDER_N, LADDER_NE, LADDER_NW},	// up
		'{LADDER_W, LADDER_NW, LADDER_SW},	// left
		'{LADDER_S, LADDER_SE, LADDER_SW}	// down
	};

endpackage

### rtl/core/ladder_keypad_autorepeat_queue.sv
// Top level: ladder keypad scanner with autorepeat and a key-code ring queue.
//
// Items enter on in_valid/in_ready with kind, pad_sample, fire_level and
// now_ticks. If enabled, kind scan decodes the ladder sample and fire pin
// into five keys, queues codes for new presses and repeats, tracks release hold.
// kind read pops one code (0 when the queue is empty); kind flush empties it.
// Every item gives exactly one result on out_valid/out_ready: key_code and
// any_held (any key marked held after that item).
//
// An accepted item is captured in the input register, decoded from there,
// and its result is loaded into the output register, where out_valid
// rises. Throughput is one item per cycle while the receiver takes each
// result; the five key slots are evaluated side by side and the queue takes
// up to five pushes per cycle, so nothing iterates.
//
// When the receiver stalls, the result holds in the output register and the
// input register still takes one more item; in_ready then drops until the
// result is taken. Reset clears the held map, the queue pointers, the
// registers to their defaults and both valids. The user writes registers
// on wr_en only while the block is idle; the block does not enforce it.
module ladder_keypad_autorepeat_queue
	import lkaq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// register write port
	input  logic                  wr_en,
	input  logic [REG_IDX_W-1:0]  wr_index,
	input  logic [REG_DATA_W-1:0] wr_data,
	// input items
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [KIND_W-1:0]     kind,
	input  logic [SAMPLE_W-1:0]   pad_sample,
	input  logic                  fire_level,
	input  logic [TICK_W-1:0]     now_ticks,
	// result items
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [CODE_W-1:0]     key_code,
	output logic                  any_held
);

	localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam logic [QW-1:0] LAST_SLOT = QW'(QUEUE_DEPTH - 1);

	// configuration registers
	logic                enable_q;
	span_t               first_delay_q;
	span_t               repeat_period_q;
	span_t               release_hold_q;
	logic [HALFW_W-1:0]  window_half_q;

	// input stage
	logic    valid_s1;
	kind_t   kind_s1;
	sample_t sample_s1;
	logic    fire_s1;
	tick_t   now_s1;

	// key and queue state
	logic [KEY_COUNT-1:0] held_q;
	tick_t                base_q [KEY_COUNT];
	tick_t                seen_q [KEY_COUNT];
	code_t                queue_q [QUEUE_DEPTH];
	logic [QW-1:0]        head_q;
	logic [QW-1:0]        tail_q;

	// result register
	logic  out_valid_q;
	code_t key_code_q;
	logic  any_held_q;

	// next-state values
	logic [KEY_COUNT-1:0] key_down;
	logic [KEY_COUNT-1:0] held_d;
	tick_t                base_d [KEY_COUNT];
	tick_t                seen_d [KEY_COUNT];
	code_t                queue_d [QUEUE_DEPTH];
	logic [QW-1:0]        head_d;
	logic [QW-1:0]        tail_d;
	code_t                code_d;

	logic advance;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// wrap-safe signed elapsed test: (int32)(a - b) >= limit
	function automatic logic elapsed(tick_t a, tick_t b, span_t limit);
		tick_t d;
		d = a - b;
		return !d[TICK_W-1] && (d[TIME_W-1:0] >= limit);
	endfunction

	// next slot in the ring
	function automatic logic [QW-1:0] ring_next(logic [QW-1:0] p);
		return (p == LAST_SLOT) ? '0 : p + 1'b1;
	endfunction

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q        <= 1'b0;
			first_delay_q   <= FIRST_DELAY_RST;
			repeat_period_q <= REPEAT_PERIOD_RST;
			release_hold_q  <= RELEASE_HOLD_RST;
			window_half_q   <= WINDOW_HALF_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_ENABLE:        enable_q        <= wr_data[0];
				REG_FIRST_DELAY:   first_delay_q   <= wr_data;
				REG_REPEAT_PERIOD: repeat_period_q <= wr_data;
				REG_RELEASE_HOLD:  release_hold_q  <= wr_data;
				REG_WINDOW_HALF:   window_half_q   <= wr_data[HALFW_W-1:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			kind_s1   <= kind;
			sample_s1 <= pad_sample;
			fire_s1   <= fire_level;
			now_s1    <= now_ticks;
		end
	end

	// ladder decode: strict windows c-w < v < c+w
	always_comb begin
		logic [SAMPLE_W:0] v;
		logic [SAMPLE_W:0] lo;
		logic [SAMPLE_W:0] hi;
		v = {1'b0, sample_s1};
		for (int k = 0; k < LADDER_KEYS; k++) begin
			key_down[k] = 1'b0;
			for (int j = 0; j < 3; j++) begin
				lo = {1'b0, LADDER_CENTERS[k][j]} - (SAMPLE_W+1)'(window_half_q);
				hi = {1'b0, LADDER_CENTERS[k][j]} + (SAMPLE_W+1)'(window_half_q);
				if (v > lo && v < hi) key_down[k] = 1'b1;
			end
		end
		key_down[KEY_COUNT-1] = !fire_s1;
	end

	// key tracking and queue update, keys in order right..fire
	always_comb begin
		logic          do_scan;
		logic          push;
		logic [QW-1:0] t;
		logic [QW-1:0] nxt;
		do_scan = (kind_s1 == KIND_SCAN) && enable_q;
		held_d  = held_q;
		base_d  = base_q;
		seen_d  = seen_q;
		queue_d = queue_q;
		head_d  = head_q;
		code_d  = CODE_NONE;
		t       = tail_q;
		for (int k = 0; k < KEY_COUNT; k++) begin
			push = 1'b0;
			if (do_scan) begin
				if (key_down[k]) begin
					if (!held_q[k]) begin
						base_d[k] = now_s1 + (TICK_W'(first_delay_q) - TICK_W'(repeat_period_q));
						held_d[k] = 1'b1;
						push      = 1'b1;
					end else if (elapsed(now_s1, base_q[k], repeat_period_q)) begin
						base_d[k] = now_s1;
						push      = 1'b1;
					end
					seen_d[k] = now_s1;
				end else if (held_q[k] && elapsed(now_s1, seen_q[k], release_hold_q)) begin
					held_d[k] = 1'b0;
				end
			end
			// drop the code when the ring is full
			nxt = ring_next(t);
			if (push && nxt != head_q) begin
				queue_d[t] = CODE_W'(k + 1);
				t          = nxt;
			end
		end
		tail_d = t;
		case (kind_s1)
			KIND_READ: begin
				if (head_q != tail_q) begin
					code_d = queue_q[head_q];
					head_d = ring_next(head_q);
				end
			end
			KIND_FLUSH: head_d = tail_q;
			default: ;
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			head_q <= '0;
			tail_q <= '0;
		end else if (advance) begin
			held_q <= held_d;
			head_q <= head_d;
			tail_q <= tail_d;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			base_q  <= base_d;
			seen_q  <= seen_d;
			queue_q <= queue_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			key_code_q <= code_d;
			any_held_q <= |held_d;
		end
	end

	assign out_valid = out_valid_q;
	assign key_code  = key_code_q;
	assign any_held  = any_held_q;

	// a delivered code is always a key code or none
	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> key_code_q <= CODE_FIRE)
		else $error("key code out of range");

	// only a read item can give a nonzero code
	a_code_only_on_read: assert property (@(posedge clk) disable iff (!arst_n)
		advance && kind_s1 != KIND_READ |=> key_code_q == CODE_NONE)
		else $error("nonzero code on a non-read item");

	// a flush leaves the queue empty
	a_flush_empties: assert property (@(posedge clk) disable iff (!arst_n)
		advance && kind_s1 == KIND_FLUSH |=> head_q == tail_q)
		else $error("queue not empty after flush");

	// any_held follows the held map after each item
	a_any_held: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> any_held_q == (|held_q))
		else $error("any_held disagrees with held map");

	// an empty input stage always takes an item
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("input stalled while empty");

endmodule
